@@ hw/rtl/sorted_table_binary_search_top_assert.svh @@
// Assertion macros used by the search table back end.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define STS_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication failed");

`define STS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication failed");

`else

`define STS_ASSERT_IMPLY(label, clk, rst_n, pre, post)

`define STS_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

@@ hw/rtl/sts_pkg.sv @@
package sts_pkg;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [2:0] STATUS_FOUND     = 3'd0;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd1;
    localparam logic [2:0] STATUS_LOADED    = 3'd2;
    localparam logic [2:0] STATUS_FULL      = 3'd3;
    localparam logic [2:0] STATUS_CLEARED   = 3'd4;

    localparam int KEY_W = 16;
    localparam int POS_W = 15;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SEARCH,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
    } q_item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PROBE,
        BK_CMP
    } back_state_t;

endpackage

@@ hw/rtl/sts_front.sv @@
module sts_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  logic [15:0]           key_value,
    output logic                  q_valid,
    output sts_pkg::q_item_t      q_item,
    input  logic                  q_pop
);
    import sts_pkg::*;

    q_item_t    fifo_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    q_item_t    decoded;
    logic       push;

    always_comb
    begin
        decoded.key = key_value;
        case (command)
            CMD_LOAD:   decoded.op = OP_LOAD;
            CMD_SEARCH: decoded.op = OP_SEARCH;
            CMD_CLEAR:  decoded.op = OP_CLEAR;
            default:    decoded.op = OP_NOP;
        endcase
    end

    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !q_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

@@ hw/rtl/sts_back.sv @@
`include "sorted_table_binary_search_top_assert.svh"

module sts_back #(
    parameter int TABLE_DEPTH = 32768
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  sts_pkg::q_item_t      q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            status,
    output logic [14:0]           position
);
    import sts_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [KEY_W-1:0] mem [TABLE_DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW-1:0]    lo_reg;
    logic [CW-1:0]    lo_next;
    logic [CW-1:0]    hix_reg;
    logic [CW-1:0]    hix_next;
    logic [AW-1:0]    mid_reg;
    logic [AW-1:0]    mid_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [2:0]       status_reg;
    logic [2:0]       status_next;
    logic [14:0]      position_reg;
    logic [14:0]      position_next;

    logic             out_free;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [CW-1:0]    span;
    logic [CW-1:0]    mid_calc;
    logic [AW+14:0]   mid_wide;
    logic             table_full;
    logic             hit;

    assign out_free   = !out_valid_reg || out_ready;
    assign table_full = (count_reg == CW'(TABLE_DEPTH));
    assign wr_addr    = count_reg[AW-1:0];
    assign hit        = (rd_data_reg == key_reg);
    assign mid_wide   = (AW + 15)'(mid_reg);

    // The window is [lo, hix); the probe sits at lo + (hix - 1 - lo) / 2.
    assign span     = hix_reg - lo_reg - CW'(1);
    assign mid_calc = lo_reg + (span >> 1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hix_next       = hix_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        position_next  = position_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop         = 1'b1;
                    position_next = '0;
                    case (q_item.op)
                        OP_LOAD:
                        begin
                            out_valid_next = 1'b1;
                            if (table_full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                count_next  = count_reg + CW'(1);
                                status_next = STATUS_LOADED;
                            end
                        end
                        OP_SEARCH:
                        begin
                            key_next   = q_item.key;
                            lo_next    = '0;
                            hix_next   = count_reg;
                            state_next = BK_PROBE;
                        end
                        OP_CLEAR:
                        begin
                            out_valid_next = 1'b1;
                            count_next     = '0;
                            status_next    = STATUS_CLEARED;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STATUS_NOT_FOUND;
                        end
                    endcase
                end
            end
            BK_PROBE:
            begin
                if (lo_reg < hix_reg)
                begin
                    mid_next   = mid_calc[AW-1:0];
                    state_next = BK_CMP;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_NOT_FOUND;
                    position_next  = '0;
                    state_next     = BK_IDLE;
                end
            end
            BK_CMP:
            begin
                if (hit)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_FOUND;
                    position_next  = mid_wide[14:0];
                    state_next     = BK_IDLE;
                end
                else
                begin
                    if (rd_data_reg > key_reg)
                    begin
                        hix_next = CW'(mid_reg);
                    end
                    else
                    begin
                        lo_next = CW'(mid_reg) + CW'(1);
                    end
                    state_next = BK_PROBE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hix_reg      <= hix_next;
        mid_reg      <= mid_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        position_reg <= position_next;
    end

    // Table memory: one write port for loads, one registered read port for probes.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= q_item.key;
        end
        rd_data_reg <= mem[mid_calc[AW-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = position_reg;

    `STS_ASSERT_IMPLY(a_pop_only_idle, clk, rst_n, q_pop, state_reg == BK_IDLE)
    `STS_ASSERT_IMPLY(a_count_in_range, clk, rst_n, 1'b1, count_reg <= CW'(TABLE_DEPTH))
    `STS_ASSERT_IMPLY(a_cmp_window_open, clk, rst_n, state_reg == BK_CMP, lo_reg < hix_reg)
    `STS_ASSERT_NEXT(a_hit_gives_result, clk, rst_n, state_reg == BK_CMP && hit,
        out_valid_reg && status_reg == STATUS_FOUND)
    `STS_ASSERT_IMPLY(a_search_out_free, clk, rst_n, state_reg != BK_IDLE, !out_valid_reg)

endmodule

@@ hw/rtl/sorted_table_binary_search_top.sv @@
// Sorted key table with binary-search membership queries.
// Input channel: in_valid/in_ready with command (0 load, 1 search, 2 clear)
// and key_value. Output channel: out_valid/out_ready with status and position.
// Every accepted item yields exactly one result, in order.
// A two-entry queue decouples the decode front from the table back end, so
// new items are taken while a result waits at the output register.
// Load, clear and unused commands finish in the cycle they leave the queue;
// the item passes through the queue, and its result through the output register.
// Each search probe runs through the PROBE state (address) and the CMP state
// (registered read and compare). A hit ends the search in CMP and an empty
// window ends it in PROBE. Probes run one after another, since the table has
// a single read port.
// Reset empties the table and the queue; memory contents are not cleared
// and need no clearing pass, since only loaded positions are ever probed.
// If the receiver stalls, the result holds in the output register, the back
// end stops taking items, and in_ready drops once the queue is full.
module sorted_table_binary_search_top #(
    parameter int TABLE_DEPTH = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [15:0] key_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [14:0] position
);
    import sts_pkg::*;

    logic    q_valid;
    logic    q_pop;
    q_item_t q_item;

    sts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .key_value (key_value),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    sts_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .position  (position)
    );

endmodule
